// ===== rtl/sipl_pkg.sv =====
// Shared types, constants and helper functions for the SIP message line parser.
`timescale 1ns / 1ps
`default_nettype none

package sipl_pkg;

	// Default limits
	localparam int unsigned MAX_HEADERS_DEF       = 64;
	localparam int unsigned MAX_MESSAGE_BYTES_DEF = 65536;

	// Record kinds
	localparam logic [2:0] KIND_REQUEST = 3'd0;
	localparam logic [2:0] KIND_STATUS  = 3'd1;
	localparam logic [2:0] KIND_HEADER  = 3'd2;
	localparam logic [2:0] KIND_BODY    = 3'd3;
	localparam logic [2:0] KIND_DONE    = 3'd4;

	// Characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result queue geometry
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [15:0] first_offset;
		logic [16:0] first_length;
		logic [15:0] second_offset;
		logic [16:0] second_length;
		logic [31:0] reply_code;
		logic [6:0]  header_index;
		logic        from_request;
		logic        last_result;
	} rec_t;

	// Records produced by one byte: an optional line record, then an optional done record
	typedef struct packed {
		logic line_ok;
		rec_t line_rec;
		logic done_ok;
		rec_t done_rec;
	} step_t;

	// Clamp a 17-bit offset to 16 bits
	function automatic logic [15:0] sat16(input logic [16:0] x);
		return x[16] ? 16'hFFFF : x[15:0];
	endfunction

	// Characters of the status line prefix "SIP/"
	function automatic logic [7:0] sip_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h53;
			2'd1: c = 8'h49;
			2'd2: c = 8'h50;
			2'd3: c = 8'h2F;
			default: c = 8'h2F;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sipl_ifs.sv =====
// Channel interfaces: raw message bytes in, parsed records out.
`timescale 1ns / 1ps
`default_nettype none

interface sipl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_end;

	modport source(output valid, output data_byte, output message_end, input ready);
	modport sink(input valid, input data_byte, input message_end, output ready);
endinterface

interface sipl_rec_if;
	logic        valid;
	logic        ready;
	logic [2:0]  record_kind;
	logic [15:0] first_offset;
	logic [16:0] first_length;
	logic [15:0] second_offset;
	logic [16:0] second_length;
	logic [31:0] reply_code;
	logic [6:0]  header_index;
	logic        from_request;
	logic        last_result;

	modport source(output valid, output record_kind, output first_offset,
		output first_length, output second_offset, output second_length,
		output reply_code, output header_index, output from_request,
		output last_result, input ready);
	modport sink(input valid, input record_kind, input first_offset,
		input first_length, input second_offset, input second_length,
		input reply_code, input header_index, input from_request,
		input last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/sipl_core.sv =====
// Parser state and per-byte line logic: builds line and done records for one byte.
`timescale 1ns / 1ps
`default_nettype none

module sipl_core #(
	parameter int unsigned MAX_HEADERS       = sipl_pkg::MAX_HEADERS_DEF,
	parameter int unsigned MAX_MESSAGE_BYTES = sipl_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  logic [7:0]    data_byte,
	input  logic          message_end,
	output sipl_pkg::step_t step
);
	import sipl_pkg::*;

	localparam logic [6:0]  HDR_LIMIT  = 7'(MAX_HEADERS);
	localparam logic [16:0] BYTE_LIMIT = 17'(MAX_MESSAGE_BYTES);
	localparam logic [2:0]  PP_MATCH   = 3'd4;
	localparam logic [2:0]  PP_FAIL    = 3'd7;

	typedef struct packed {
		logic [15:0] off;
		logic [16:0] len;
	} span_t;

	function automatic span_t span(input logic fv, input logic [15:0] f,
		input logic lv, input logic [15:0] l);
		span_t s;
		s = '0;
		if (fv && lv && l >= f) begin
			s.off = f;
			s.len = {1'b0, l - f} + 17'd1;
		end
		return s;
	endfunction

	// Message state
	logic [16:0] bp_q, bp_d;
	logic [16:0] ls_q, ls_d;
	logic        first_q, first_d;
	logic        body_q, body_d;
	logic [2:0]  pp_q, pp_d;
	logic [1:0]  sc_q, sc_d;
	logic [15:0] sp1_q, sp1_d;
	logic [31:0] code_q, code_d;
	logic [6:0]  hc_q, hc_d;
	logic        req_q, req_d;
	// Line state
	logic        lf_v_q, lf_v_d, ll_v_q, ll_v_d;
	logic [15:0] lf_q, lf_d, ll_q, ll_d;
	logic        sf_v_q, sf_v_d, sl_v_q, sl_v_d;
	logic [15:0] sf_q, sf_d, sl_q, sl_d;
	logic        nf_v_q, nf_v_d, nl_v_q, nl_v_d;
	logic [15:0] nf_q, nf_d, nl_q, nl_d;
	logic        colon_q, colon_d;

	// Per-byte decode
	logic [15:0] pos;
	logic        byte_ok, is_lf, nb_first, nb_last, is_digit;
	logic        take, fin, do_seg, status;
	span_t       sp_a, sp_b;

	assign pos      = bp_q[15:0];
	assign byte_ok  = bp_q < BYTE_LIMIT;
	assign is_lf    = data_byte == CH_LF;
	assign nb_first = data_byte != CH_SPACE && data_byte != CH_TAB;
	assign nb_last  = nb_first && data_byte != CH_CR;
	assign is_digit = data_byte >= CH_ZERO && data_byte <= CH_NINE;
	assign take     = valid && byte_ok && !body_q && !is_lf;
	assign fin      = valid && !body_q && ((byte_ok && is_lf) || message_end);

	// Next state and records for the byte in the input register
	always_comb begin
		bp_d = bp_q; ls_d = ls_q; first_d = first_q; body_d = body_q;
		pp_d = pp_q; sc_d = sc_q; sp1_d = sp1_q; code_d = code_q;
		hc_d = hc_q; req_d = req_q;
		lf_v_d = lf_v_q; lf_d = lf_q; ll_v_d = ll_v_q; ll_d = ll_q;
		sf_v_d = sf_v_q; sf_d = sf_q; sl_v_d = sl_v_q; sl_d = sl_q;
		nf_v_d = nf_v_q; nf_d = nf_q; nl_v_d = nl_v_q; nl_d = nl_q;
		colon_d = colon_q;
		do_seg = 1'b0;
		status = 1'b0;
		sp_a = '0;
		sp_b = '0;
		step = '0;

		if (valid && byte_ok) begin
			bp_d = bp_q + 17'd1;
		end

		// Take a byte that is not a line end
		if (take) begin
			if (nb_first && !lf_v_q) begin
				lf_v_d = 1'b1;
				lf_d = pos;
			end
			if (nb_last) begin
				ll_v_d = 1'b1;
				ll_d = pos;
			end
			if (first_q) begin
				if (lf_v_d) begin
					if (pp_q < PP_MATCH) begin
						pp_d = (data_byte == sip_char(pp_q[1:0])) ? pp_q + 3'd1 : PP_FAIL;
					end
					if (sc_q == 2'd1 && data_byte != CH_SPACE) begin
						if (pp_d == PP_MATCH) begin
							if (is_digit) begin
								code_d = {code_q[28:0], 3'b000} + {code_q[30:0], 1'b0}
									+ {24'd0, data_byte - CH_ZERO};
							end
						end else begin
							do_seg = 1'b1;
						end
					end else if (sc_q == 2'd2 && pp_d == PP_MATCH) begin
						do_seg = 1'b1;
					end
					if (data_byte == CH_SPACE) begin
						if (sc_q == 2'd0) begin
							sp1_d = pos;
							sc_d = 2'd1;
						end else if (sc_q == 2'd1) begin
							sc_d = 2'd2;
						end
					end
				end
			end else if (data_byte == CH_COLON && !colon_q) begin
				colon_d = 1'b1;
				nf_v_d = sf_v_q; nf_d = sf_q;
				nl_v_d = sl_v_q; nl_d = sl_q;
				sf_v_d = 1'b0;
				sl_v_d = 1'b0;
			end else begin
				do_seg = 1'b1;
			end
			if (do_seg) begin
				if (nb_first && !sf_v_q) begin
					sf_v_d = 1'b1;
					sf_d = pos;
				end
				if (nb_last) begin
					sl_v_d = 1'b1;
					sl_d = pos;
				end
			end
		end

		// Finish the line at LF or at the message end
		if (fin) begin
			if (first_q) begin
				status = pp_d == PP_MATCH;
				req_d = !status;
				first_d = 1'b0;
				step.line_ok = 1'b1;
				if (status) begin
					sp_a = span(sf_v_d, sf_d, sl_v_d, sl_d);
					step.line_rec.record_kind = KIND_STATUS;
					step.line_rec.reply_code = code_d;
					step.line_rec.first_offset = sp_a.off;
					step.line_rec.first_length = sp_a.len;
				end else begin
					step.line_rec.record_kind = KIND_REQUEST;
					if (sc_d != 2'd0 && ll_v_d && lf_v_d && sp1_d < ll_d && sp1_d >= lf_d) begin
						sp_b = span(sf_v_d, sf_d, sl_v_d, sl_d);
						step.line_rec.first_offset = lf_d;
						step.line_rec.first_length = {1'b0, sp1_d - lf_d};
						step.line_rec.second_offset = sp_b.off;
						step.line_rec.second_length = sp_b.len;
					end
				end
			end else if (!ll_v_d) begin
				body_d = 1'b1;
				if (byte_ok && is_lf) begin
					step.line_ok = 1'b1;
					step.line_rec.record_kind = KIND_BODY;
					step.line_rec.first_offset = sat16(bp_d);
				end
			end else if (colon_d && hc_q < HDR_LIMIT) begin
				sp_a = span(nf_v_d, nf_d, nl_v_d, nl_d);
				sp_b = span(sf_v_d, sf_d, sl_v_d, sl_d);
				step.line_ok = 1'b1;
				step.line_rec.record_kind = KIND_HEADER;
				step.line_rec.first_offset = sp_a.off;
				step.line_rec.first_length = sp_a.len;
				step.line_rec.second_offset = sp_b.off;
				step.line_rec.second_length = sp_b.len;
				step.line_rec.header_index = hc_q;
				hc_d = hc_q + 7'd1;
			end
			step.line_rec.from_request = req_d;
			ls_d = bp_d;
			lf_v_d = 1'b0; ll_v_d = 1'b0; sf_v_d = 1'b0; sl_v_d = 1'b0;
			nf_v_d = 1'b0; nl_v_d = 1'b0; colon_d = 1'b0;
		end

		// Close the message and return to the reset state
		if (valid && message_end) begin
			step.done_ok = 1'b1;
			step.done_rec.record_kind = KIND_DONE;
			step.done_rec.first_offset = sat16(ls_d);
			step.done_rec.first_length = bp_d;
			step.done_rec.header_index = hc_d;
			step.done_rec.from_request = req_d;
			step.done_rec.last_result = 1'b1;
			bp_d = '0; ls_d = '0; first_d = 1'b1; body_d = 1'b0;
			pp_d = '0; sc_d = '0; sp1_d = '0; code_d = '0; hc_d = '0; req_d = 1'b0;
			lf_v_d = 1'b0; ll_v_d = 1'b0; sf_v_d = 1'b0; sl_v_d = 1'b0;
			nf_v_d = 1'b0; nl_v_d = 1'b0; colon_d = 1'b0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q <= '0; ls_q <= '0; first_q <= 1'b1; body_q <= 1'b0;
			pp_q <= '0; sc_q <= '0; sp1_q <= '0; code_q <= '0; hc_q <= '0;
			req_q <= 1'b0;
			lf_v_q <= 1'b0; lf_q <= '0; ll_v_q <= 1'b0; ll_q <= '0;
			sf_v_q <= 1'b0; sf_q <= '0; sl_v_q <= 1'b0; sl_q <= '0;
			nf_v_q <= 1'b0; nf_q <= '0; nl_v_q <= 1'b0; nl_q <= '0;
			colon_q <= 1'b0;
		end else begin
			bp_q <= bp_d; ls_q <= ls_d; first_q <= first_d; body_q <= body_d;
			pp_q <= pp_d; sc_q <= sc_d; sp1_q <= sp1_d; code_q <= code_d; hc_q <= hc_d;
			req_q <= req_d;
			lf_v_q <= lf_v_d; lf_q <= lf_d; ll_v_q <= ll_v_d; ll_q <= ll_d;
			sf_v_q <= sf_v_d; sf_q <= sf_d; sl_v_q <= sl_v_d; sl_q <= sl_d;
			nf_v_q <= nf_v_d; nf_q <= nf_d; nl_v_q <= nl_v_d; nl_q <= nl_d;
			colon_q <= colon_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sipl_rec_queue.sv =====
// Result queue: takes up to two records a cycle, hands out one record per transaction.
`timescale 1ns / 1ps
`default_nettype none

module sipl_rec_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sipl_pkg::step_t                   push,
	output logic [sipl_pkg::RQ_CNT_W-1:0]     count,
	sipl_rec_if.source                        rec_out
);
	import sipl_pkg::*;

	rec_t                entry_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_q, rd_q, wr_nx;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic [1:0]          n_push;
	logic                pop;
	rec_t                head;

	assign n_push = {1'b0, push.line_ok} + {1'b0, push.done_ok};
	assign pop    = rec_out.valid && rec_out.ready;
	assign wr_nx  = wr_q + RQ_PTR_W'(1);
	assign count  = cnt_q;

	// Write the line record first, the done record behind it
	always_ff @(posedge clk) begin
		if (push.line_ok) begin
			entry_q[wr_q] <= push.line_rec;
		end
		if (push.done_ok) begin
			entry_q[push.line_ok ? wr_nx : wr_q] <= push.done_rec;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + RQ_PTR_W'(n_push);
			if (pop) begin
				rd_q <= rd_q + RQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + RQ_CNT_W'(n_push) - RQ_CNT_W'(pop);
		end
	end

	// Present the head record
	assign head                  = entry_q[rd_q];
	assign rec_out.valid         = cnt_q != '0;
	assign rec_out.record_kind   = head.record_kind;
	assign rec_out.first_offset  = head.first_offset;
	assign rec_out.first_length  = head.first_length;
	assign rec_out.second_offset = head.second_offset;
	assign rec_out.second_length = head.second_length;
	assign rec_out.reply_code    = head.reply_code;
	assign rec_out.header_index  = head.header_index;
	assign rec_out.from_request  = head.from_request;
	assign rec_out.last_result   = head.last_result;

endmodule

`default_nettype wire

// ===== rtl/sip_message_line_parser.sv =====
// Top level of the SIP message line parser: input register, parser core, result queue.
//
//   channel   modport  direction  contents
//   msg_in    sink     in         data_byte, message_end (one message byte)
//   rec_out   source   out        one parsed record (request, status, header, body, done)
//
// One byte is accepted per cycle while msg_in.ready is high; its records go via the input register and the queue.
// A byte yields at most two records (a line record and the done record), so a run of such
// bytes drains at one record per cycle while rec_out.ready is high, and input then slows to match.
// msg_in.ready drops when the four-entry result queue lacks room for the byte in the
// input register plus two more records; rec_out stalls back up through the queue only.
// Reset arst_n is asynchronous and returns the parser to the start of a message.
`timescale 1ns / 1ps
`default_nettype none

module sip_message_line_parser #(
	parameter int unsigned MAX_HEADERS       = sipl_pkg::MAX_HEADERS_DEF,
	parameter int unsigned MAX_MESSAGE_BYTES = sipl_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sipl_byte_if.sink   msg_in,
	sipl_rec_if.source  rec_out
);
	import sipl_pkg::*;

	localparam int unsigned SUM_W = RQ_CNT_W + 1;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                accept;
	step_t               step;
	logic [RQ_CNT_W-1:0] q_count;
	logic [1:0]          n_push;

	// Accept only when the queue can absorb this cycle's records and two more
	assign n_push = {1'b0, step.line_ok} + {1'b0, step.done_ok};
	assign msg_in.ready = (SUM_W'(q_count) + SUM_W'(n_push) + SUM_W'(2)) <= SUM_W'(RQ_DEPTH);
	assign accept = msg_in.valid && msg_in.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= msg_in.data_byte;
			end_s1 <= msg_in.message_end;
		end
	end

	sipl_core #(
		.MAX_HEADERS      (MAX_HEADERS),
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.data_byte  (byte_s1),
		.message_end(end_s1),
		.step       (step)
	);

	sipl_rec_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.count  (q_count),
		.rec_out(rec_out)
	);

endmodule

`default_nettype wire

// ===== rtl/sipl_checker.sv =====
// Port checker for the SIP message line parser and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sipl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [15:0] first_offset,
	input logic [16:0] first_length,
	input logic        last_result
);
	import sipl_pkg::*;

	// Hold a stalled record
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(first_offset))
		else $error("stalled record changed");

	// Flag only the done record as last
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_result == (kind == KIND_DONE)))
		else $error("last_result does not match done record");

	// Expect a record at the output once a final byte has passed the input register and the queue
	a_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_end |-> ##2 out_valid)
		else $error("no record after final byte");

	// Keep the body offset within the message length
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DONE |-> {1'b0, first_offset} <= first_length)
		else $error("body offset beyond message length");

endmodule

bind sip_message_line_parser sipl_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (msg_in.valid),
	.in_ready    (msg_in.ready),
	.in_end      (msg_in.message_end),
	.out_valid   (rec_out.valid),
	.out_ready   (rec_out.ready),
	.kind        (rec_out.record_kind),
	.first_offset(rec_out.first_offset),
	.first_length(rec_out.first_length),
	.last_result (rec_out.last_result)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the SIP message line parser: byte stimulus, record prediction.
`timescale 1ns / 1ps

module tb_top;
	import sipl_pkg::*;

	localparam int unsigned HDR_LIMIT    = MAX_HEADERS_DEF;
	localparam int unsigned BYTE_LIMIT   = MAX_MESSAGE_BYTES_DEF;
	localparam logic [16:0] NO_POS       = 17'h1FFFF;
	localparam logic [31:0] SIP_TAG      = "SIP/";
	localparam int unsigned RANDOM_BYTES = 1000;
	localparam int unsigned DRAIN_CYCLES = 20;

	// Predicts the record stream of the parser and compares it with what comes out
	class sip_record_scoreboard;
		rec_t        pending_recs[$];
		int unsigned mismatches;
		int unsigned records_checked;
		logic [16:0] byte_count, line_begin, colon_at;
		logic [16:0] seg_lo, seg_hi, line_lo, line_hi, name_lo, name_hi;
		logic [15:0] space_a;
		logic        first_line, body_seen, req_line;
		logic [2:0]  sip_match;
		logic [1:0]  spaces;
		logic [31:0] code_acc;
		logic [6:0]  hdr_count;

		function new();
			mismatches = 0;
			records_checked = 0;
			restart();
		endfunction

		function void clear_line();
			line_lo = NO_POS;
			line_hi = NO_POS;
			seg_lo = NO_POS;
			seg_hi = NO_POS;
			name_lo = NO_POS;
			name_hi = NO_POS;
			colon_at = NO_POS;
		endfunction

		// Return to the start of a message
		function void restart();
			byte_count = '0;
			line_begin = '0;
			first_line = 1'b1;
			body_seen = 1'b0;
			sip_match = '0;
			spaces = '0;
			space_a = '0;
			code_acc = '0;
			hdr_count = '0;
			req_line = 1'b0;
			clear_line();
		endfunction

		// Widen a trimmed span by one nonblank character
		function void mark(inout logic [16:0] lo, inout logic [16:0] hi,
			input logic [7:0] c, input logic [16:0] p);
			if (c != CH_SPACE && c != CH_TAB && lo == NO_POS)
				lo = p;
			if (c != CH_SPACE && c != CH_TAB && c != CH_CR)
				hi = p;
		endfunction

		// Offset and length of a span; an empty span reads as zero
		function logic [32:0] span(logic [16:0] lo, logic [16:0] hi);
			logic [16:0] len;
			if (lo != NO_POS && hi != NO_POS && hi >= lo) begin
				len = hi - lo + 17'd1;
				return {lo[15:0], len};
			end
			return '0;
		endfunction

		function logic [15:0] clamp16(logic [16:0] x);
			return x[16] ? 16'hFFFF : x[15:0];
		endfunction

		function void push_rec(rec_t r);
			r.from_request = req_line;
			pending_recs.push_back(r);
		endfunction

		// Finish the current line at LF or at the message end
		function void close_line(logic [16:0] next_start, bit at_lf);
			rec_t r;
			r = '0;
			if (first_line) begin
				req_line = (sip_match != 3'd4);
				if (!req_line) begin
					r.record_kind = KIND_STATUS;
					r.reply_code = code_acc;
					{r.first_offset, r.first_length} = span(seg_lo, seg_hi);
				end else begin
					r.record_kind = KIND_REQUEST;
					if (spaces >= 2'd1 && line_hi != NO_POS && line_lo != NO_POS &&
						{1'b0, space_a} < line_hi && {1'b0, space_a} >= line_lo) begin
						r.first_offset = line_lo[15:0];
						r.first_length = {1'b0, space_a} - line_lo;
						{r.second_offset, r.second_length} = span(seg_lo, seg_hi);
					end
				end
				push_rec(r);
				first_line = 1'b0;
			end else if (line_hi == NO_POS) begin
				body_seen = 1'b1;
				line_begin = next_start;
				if (at_lf) begin
					r.record_kind = KIND_BODY;
					r.first_offset = clamp16(next_start);
					push_rec(r);
				end
			end else if (colon_at != NO_POS && hdr_count < HDR_LIMIT) begin
				r.record_kind = KIND_HEADER;
				{r.first_offset, r.first_length} = span(name_lo, name_hi);
				{r.second_offset, r.second_length} = span(seg_lo, seg_hi);
				r.header_index = hdr_count;
				push_rec(r);
				hdr_count++;
			end
			clear_line();
			if (!body_seen)
				line_begin = next_start;
		endfunction

		// Fold one non-LF byte into the line state
		function void take_char(logic [7:0] c, logic [16:0] p);
			int unsigned k;
			logic [7:0]  want_c;
			mark(line_lo, line_hi, c, p);
			if (first_line) begin
				if (line_lo != NO_POS) begin
					if (sip_match < 3'd4) begin
						k = sip_match[1:0];
						want_c = SIP_TAG[31 - 8 * k -: 8];
						sip_match = (c == want_c) ? sip_match + 3'd1 : 3'd7;
					end
					if (spaces == 2'd1 && c != CH_SPACE) begin
						if (sip_match == 3'd4) begin
							if (c >= CH_ZERO && c <= CH_NINE)
								code_acc = code_acc * 32'd10 + {24'd0, c - CH_ZERO};
						end else begin
							mark(seg_lo, seg_hi, c, p);
						end
					end else if (spaces == 2'd2 && sip_match == 3'd4) begin
						mark(seg_lo, seg_hi, c, p);
					end
					if (c == CH_SPACE) begin
						if (spaces == 2'd0) begin
							space_a = p[15:0];
							spaces = 2'd1;
						end else if (spaces == 2'd1) begin
							spaces = 2'd2;
						end
					end
				end
			end else if (c == CH_COLON && colon_at == NO_POS) begin
				colon_at = p;
				name_lo = seg_lo;
				name_hi = seg_hi;
				seg_lo = NO_POS;
				seg_hi = NO_POS;
			end else begin
				mark(seg_lo, seg_hi, c, p);
			end
		endfunction

		// Note one accepted byte transaction and queue the records it causes
		function void note_byte(logic [7:0] c, bit last);
			logic [16:0] p;
			rec_t        r;
			if (byte_count < BYTE_LIMIT) begin
				p = byte_count;
				byte_count++;
				if (!body_seen) begin
					if (c == CH_LF)
						close_line(p + 17'd1, 1'b1);
					else
						take_char(c, p);
				end
			end
			if (last) begin
				if (!body_seen)
					close_line(byte_count, 1'b0);
				r = '0;
				r.record_kind = KIND_DONE;
				r.first_offset = clamp16(line_begin);
				r.first_length = byte_count;
				r.header_index = hdr_count;
				r.last_result = 1'b1;
				push_rec(r);
				restart();
			end
		endfunction

		function void cmp_field(string nm, logic [31:0] want_v, logic [31:0] got_v);
			if (got_v !== want_v) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, want_v, got_v);
				mismatches++;
			end
		endfunction

		// Compare one record transaction with the oldest expectation
		function void check_record(rec_t got);
			rec_t want;
			records_checked++;
			if (pending_recs.size() == 0) begin
				$display("%0t: unexpected record: expected none, actual kind %0d",
					$time, got.record_kind);
				mismatches++;
			end else begin
				want = pending_recs.pop_front();
				cmp_field("record_kind", want.record_kind, got.record_kind);
				cmp_field("first_offset", want.first_offset, got.first_offset);
				cmp_field("first_length", want.first_length, got.first_length);
				cmp_field("second_offset", want.second_offset, got.second_offset);
				cmp_field("second_length", want.second_length, got.second_length);
				cmp_field("reply_code", want.reply_code, got.reply_code);
				cmp_field("header_index", want.header_index, got.header_index);
				cmp_field("from_request", want.from_request, got.from_request);
				cmp_field("last_result", want.last_result, got.last_result);
			end
		endfunction

		function int unsigned outstanding();
			return pending_recs.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sipl_byte_if msg_if();
	sipl_rec_if  rec_if();

	sip_message_line_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_in(msg_if),
		.rec_out(rec_if)
	);

	sip_record_scoreboard sb;
	int unsigned          send_idle_pct;
	int unsigned          recv_stall_pct;
	int unsigned          bytes_sent;
	int unsigned          messages_sent;
	logic [7:0]           msg_bytes[$];

	always #5 clk = ~clk;

	// Stall the record channel at random
	always @(negedge clk)
		rec_if.ready = ($urandom_range(99) >= recv_stall_pct);

	// Check every accepted record transaction
	always @(posedge clk) begin
		rec_t got;
		if (arst_n === 1'b1 && rec_if.valid === 1'b1 && rec_if.ready === 1'b1) begin
			got.record_kind = rec_if.record_kind;
			got.first_offset = rec_if.first_offset;
			got.first_length = rec_if.first_length;
			got.second_offset = rec_if.second_offset;
			got.second_length = rec_if.second_length;
			got.reply_code = rec_if.reply_code;
			got.header_index = rec_if.header_index;
			got.from_request = rec_if.from_request;
			got.last_result = rec_if.last_result;
			sb.check_record(got);
		end
	end

	// Message assembly helpers
	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endfunction

	function automatic void add_line(string s, bit with_cr);
		add_str(s);
		if (with_cr)
			msg_bytes.push_back(CH_CR);
		msg_bytes.push_back(CH_LF);
	endfunction

	function automatic logic [7:0] text_char();
		string      punct = "/;=@.<>-:_";
		logic [7:0] v;
		case ($urandom_range(9))
			0, 1, 2: v = 8'h61 + 8'($urandom_range(25));
			3, 4: v = 8'h41 + 8'($urandom_range(25));
			5: v = CH_ZERO + 8'($urandom_range(9));
			6: v = punct[$urandom_range(punct.len() - 1)];
			7: v = CH_SPACE;
			8: v = CH_TAB;
			default: begin
				v = 8'($urandom_range(255));
				if (v == CH_LF)
					v = CH_CR;
			end
		endcase
		return v;
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] v;
		case ($urandom_range(7))
			0: v = CH_LF;
			1: v = CH_CR;
			2: v = CH_SPACE;
			3: v = CH_TAB;
			4: v = CH_COLON;
			default: v = 8'($urandom_range(255));
		endcase
		return v;
	endfunction

	function automatic void add_text(int unsigned lo, int unsigned hi);
		repeat ($urandom_range(hi, lo))
			msg_bytes.push_back(text_char());
	endfunction

	function automatic void add_token(int unsigned lo, int unsigned hi);
		repeat ($urandom_range(hi, lo))
			msg_bytes.push_back(8'h41 + 8'($urandom_range(25)));
	endfunction

	function automatic void add_blanks(int unsigned max_n);
		repeat ($urandom_range(max_n))
			msg_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
	endfunction

	function automatic void add_eol();
		case ($urandom_range(3))
			0: msg_bytes.push_back(CH_CR);
			1: begin
				msg_bytes.push_back(CH_SPACE);
				msg_bytes.push_back(CH_CR);
			end
			default: ;
		endcase
		msg_bytes.push_back(CH_LF);
	endfunction

	// Build one random message: mostly well formed, sometimes pure noise
	function automatic void build_random_message();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(40, 1))
				msg_bytes.push_back(noise_char());
		end else begin
			add_blanks(2);
			if ($urandom_range(1)) begin
				add_str(($urandom_range(7) == 0) ? "SIP2" : "SIP/2.0");
				if ($urandom_range(7) != 0) begin
					msg_bytes.push_back(CH_SPACE);
					repeat ($urandom_range(12))
						msg_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
					if ($urandom_range(7) != 0) begin
						msg_bytes.push_back(CH_SPACE);
						add_text(0, 12);
					end
				end
			end else begin
				add_token(0, 8);
				if ($urandom_range(7) != 0) begin
					msg_bytes.push_back(CH_SPACE);
					add_text(0, 16);
					if ($urandom_range(1))
						add_str(" SIP/2.0");
				end
			end
			add_eol();
			repeat ($urandom_range(6)) begin
				if ($urandom_range(7) == 0) begin
					add_text(1, 12);
				end else begin
					add_blanks(1);
					add_token(0, 8);
					add_blanks(1);
					msg_bytes.push_back(CH_COLON);
					add_blanks(2);
					add_text(0, 16);
				end
				add_eol();
			end
			case ($urandom_range(3))
				0: ;
				1: begin
					add_eol();
					repeat ($urandom_range(20))
						msg_bytes.push_back(noise_char());
				end
				2: msg_bytes.push_back($urandom_range(1) ? CH_CR : CH_SPACE);
				default: begin
					add_token(1, 6);
					msg_bytes.push_back(CH_COLON);
					add_text(0, 8);
				end
			endcase
		end
	endfunction

	// Drive one byte transaction, with random gaps ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			msg_if.valid = 1'b0;
			@(negedge clk);
		end
		msg_if.valid = 1'b1;
		msg_if.data_byte = b;
		msg_if.message_end = last;
		@(posedge clk);
		while (msg_if.ready !== 1'b1)
			@(posedge clk);
		sb.note_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_message();
		int unsigned n;
		n = msg_bytes.size();
		for (int unsigned i = 0; i < n; i++)
			send_byte(msg_bytes[i], i == n - 1);
		msg_bytes.delete();
		messages_sent++;
	endtask

	// Hand-written messages: extremes and corner cases of the line rules
	task automatic directed_messages();
		// full request with headers and a body
		add_line("INVITE sip:bob@example SIP/2.0", 1);
		add_line("Via: SIP/2.0/UDP host", 1);
		add_line("To : <sip:a> ", 1);
		add_line("", 1);
		add_str("body!");
		send_message();
		// status line with blanks around it; message ends on the blank line LF
		add_line("  SIP/2.0 200 OK \t", 1);
		add_line("CSeq:1", 0);
		add_line("", 0);
		send_message();
		// status line without any space, final line without LF
		add_str("SIP/2.0");
		send_message();
		// status line without a second space, final header line
		add_line("SIP/2.0 180", 0);
		add_str("X:y");
		send_message();
		// status code that wraps
		add_line("SIP/2.0 99999999999 Big", 1);
		add_line("", 1);
		send_message();
		// request without space, malformed and empty headers, blank final line
		add_line("OPTIONS", 0);
		add_line("garbage line", 0);
		add_line("A:", 0);
		add_line(" : v ", 0);
		msg_bytes.push_back(CH_CR);
		send_message();
		// tabs around the request line, body with high bytes
		add_line("\t\tREGISTER\t x \t", 1);
		add_line("", 0);
		msg_bytes.push_back(8'hFF);
		msg_bytes.push_back(8'h80);
		msg_bytes.push_back(8'h00);
		send_message();
		// trailing space only, and a prefix that falls short of a status line
		add_line("X   ", 0);
		add_str("Y:1");
		send_message();
		add_line("SIP 200 OK", 0);
		send_message();
		// one-byte messages
		msg_bytes.push_back(CH_LF);
		send_message();
		add_str("A");
		send_message();
		// more headers than the parser keeps
		add_line("BYE u", 0);
		repeat (HDR_LIMIT + 6)
			add_line("H:v", 0);
		add_line("", 0);
		send_message();
	endtask

	initial begin
		int unsigned random_base;
		int unsigned phase_target;
		sb = new();
		arst_n = 1'b0;
		msg_if.valid = 1'b0;
		msg_if.data_byte = '0;
		msg_if.message_end = 1'b0;
		rec_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		messages_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_messages();

		// Random messages under four handshake pressure phases
		random_base = bytes_sent;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct = 36;
				end
			endcase
			phase_target = random_base + RANDOM_BYTES * (ph + 1) / 4;
			while (bytes_sent < phase_target) begin
				build_random_message();
				send_message();
			end
		end
		msg_if.valid = 1'b0;

		// Drain outstanding records, then watch for strays
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d messages (%0d bytes) under four handshake phases; checked %0d records.",
			messages_sent, bytes_sent, sb.records_checked);
		$display("Covered request/status lines, header overflow, blank and unterminated final lines.");
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("Timeout with %0d records outstanding.", sb.outstanding());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sipl_pkg.sv
rtl/sipl_ifs.sv
rtl/sipl_core.sv
rtl/sipl_rec_queue.sv
rtl/sip_message_line_parser.sv
rtl/sipl_checker.sv
tb/tb_top.sv
